[hdl/segmented_command_deframer_core_defines.svh]
// ----------------------------------------------------------------------------
// Segmented command deframer assertion macros
// Shared property shorthands for the deframer checks.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_COMMAND_DEFRAMER_CORE_DEFINES_SVH
`define SEGMENTED_COMMAND_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define SCDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define SCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

[hdl/scdf_pkg.sv]
// ----------------------------------------------------------------------------
// Segmented command deframer package
// Shared types and constants for the deframer.
// ----------------------------------------------------------------------------
package scdf_pkg;

    localparam logic [7:0] MAX_DATA_LEN_RESET = 8'd96;
    localparam logic [2:0] HDR_LEN_MASK       = 3'b111;
    localparam logic [7:0] MIN_SEG_LEN        = 8'd2;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_SIZE_MISMATCH = 2'd1,
        STATUS_BAD_LENGTH    = 2'd2,
        STATUS_TRUNCATED     = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] datagram_size;
        logic [7:0]  sender_id;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  command;
        logic [7:0]  sender;
        logic [7:0]  segment_data_len;
        logic        has_data;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic        segment_end;
    } out_item_t;

endpackage

[hdl/scdf_byte_if.sv]
// ----------------------------------------------------------------------------
// Deframer byte channel
// Valid/ready channel carrying one received datagram byte with its context.
// ----------------------------------------------------------------------------
interface scdf_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] datagram_size;
    logic [7:0]  sender_id;

    modport source (output valid, output data_byte, output first_byte,
                    output datagram_size, output sender_id, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input datagram_size, input sender_id, output ready);
endinterface

[hdl/scdf_result_if.sv]
// ----------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying one deframed result.
// ----------------------------------------------------------------------------
interface scdf_result_if
    import scdf_pkg::*;
;
    logic        valid;
    logic        ready;
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  sender;
    logic [7:0]  segment_data_len;
    logic        has_data;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic        segment_end;

    modport source (output valid, output status, output command, output sender,
                    output segment_data_len, output has_data, output payload_byte,
                    output byte_index, output segment_end, input ready);
    modport sink   (input valid, input status, input command, input sender,
                    input segment_data_len, input has_data, input payload_byte,
                    input byte_index, input segment_end, output ready);
endinterface

[hdl/scdf_in_stage.sv]
// ----------------------------------------------------------------------------
// Deframer input register
// Captures one byte transfer and holds it until the parser advances.
// ----------------------------------------------------------------------------
module scdf_in_stage
    import scdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    input  logic      advance,
    output logic      valid,
    output in_item_t  item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ready = !valid_reg || advance;
    assign valid    = valid_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[hdl/scdf_parse.sv]
// ----------------------------------------------------------------------------
// Deframer segment parser
// Walks header and segments one byte at a time and registers each result.
// ----------------------------------------------------------------------------
module scdf_parse
    import scdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       valid,
    input  in_item_t   item,
    output logic       advance,
    input  logic       res_ready,
    output logic       res_valid,
    output out_item_t  res
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_HDR1,
        PH_SEGLEN,
        PH_SEGCMD,
        PH_DATA
    } phase_t;

    logic [7:0]  max_len_reg;
    phase_t      phase_reg, phase_next;
    logic [10:0] pkt_len_reg, pkt_len_next;
    logic [10:0] pos_reg, pos_next;
    logic [7:0]  seg_len_reg, seg_len_next;
    logic [7:0]  seg_cmd_reg, seg_cmd_next;
    logic [7:0]  data_cnt_reg, data_cnt_next;
    logic [7:0]  sender_reg, sender_next;
    logic        res_valid_reg, res_valid_next;
    out_item_t   res_reg, res_next;

    logic [7:0]  b;
    logic [10:0] pkt_len_hdr;
    logic [11:0] end_pos;
    logic [7:0]  dlen;
    logic        last;
    logic        emit;
    out_item_t   calc;

    assign advance   = valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign b           = item.data_byte;
    assign pkt_len_hdr = {pkt_len_reg[10:8], b};
    assign end_pos     = {1'b0, pos_reg} + {4'b0, b};
    assign dlen        = seg_len_reg - MIN_SEG_LEN;
    assign last        = ({1'b0, data_cnt_reg} + 9'd1) >= {1'b0, dlen};

    always_comb
    begin
        phase_next    = phase_reg;
        pkt_len_next  = pkt_len_reg;
        pos_next      = pos_reg;
        seg_len_next  = seg_len_reg;
        seg_cmd_next  = seg_cmd_reg;
        data_cnt_next = data_cnt_reg;
        sender_next   = sender_reg;
        emit          = 1'b0;
        calc          = '0;
        calc.status   = STATUS_OK;
        calc.sender   = sender_reg;

        if (item.first_byte)
        begin
            sender_next   = item.sender_id;
            calc.sender   = item.sender_id;
            pkt_len_next  = {b[2:0] & HDR_LEN_MASK, 8'd0};
            pos_next      = 11'd1;
            seg_len_next  = '0;
            seg_cmd_next  = '0;
            data_cnt_next = '0;
            phase_next    = PH_HDR1;
        end
        else
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    pkt_len_next = pkt_len_hdr;
                    pos_next     = 11'd2;
                    if (item.datagram_size != {5'd0, pkt_len_hdr})
                    begin
                        phase_next  = PH_WAIT;
                        emit        = 1'b1;
                        calc.status = STATUS_SIZE_MISMATCH;
                    end
                    else
                    begin
                        phase_next = (11'd2 >= pkt_len_hdr) ? PH_WAIT : PH_SEGLEN;
                    end
                end
                PH_SEGLEN:
                begin
                    seg_len_next = b;
                    if (b < MIN_SEG_LEN || (b - MIN_SEG_LEN) > max_len_reg)
                    begin
                        phase_next  = PH_WAIT;
                        emit        = 1'b1;
                        calc.status = STATUS_BAD_LENGTH;
                    end
                    else if (end_pos > {1'b0, pkt_len_reg})
                    begin
                        phase_next  = PH_WAIT;
                        emit        = 1'b1;
                        calc.status = STATUS_TRUNCATED;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 11'd1;
                        phase_next = PH_SEGCMD;
                    end
                end
                PH_SEGCMD:
                begin
                    seg_cmd_next  = b;
                    data_cnt_next = '0;
                    pos_next      = pos_reg + 11'd1;
                    if (seg_len_reg == MIN_SEG_LEN)
                    begin
                        phase_next       = (pos_next >= pkt_len_reg) ? PH_WAIT : PH_SEGLEN;
                        emit             = 1'b1;
                        calc.command     = b;
                        calc.segment_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    pos_next      = pos_reg + 11'd1;
                    data_cnt_next = data_cnt_reg + 8'd1;
                    if (last)
                    begin
                        phase_next = (pos_next >= pkt_len_reg) ? PH_WAIT : PH_SEGLEN;
                    end
                    emit                  = 1'b1;
                    calc.command          = seg_cmd_reg;
                    calc.segment_data_len = dlen;
                    calc.has_data         = 1'b1;
                    calc.payload_byte     = b;
                    calc.byte_index       = data_cnt_reg;
                    calc.segment_end      = last;
                end
                PH_WAIT:
                begin
                    phase_next = PH_WAIT;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        if (advance)
        begin
            res_valid_next = emit;
            res_next       = calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_DATA_LEN_RESET;
            phase_reg     <= PH_WAIT;
            pkt_len_reg   <= '0;
            pos_reg       <= '0;
            seg_len_reg   <= '0;
            seg_cmd_reg   <= '0;
            data_cnt_reg  <= '0;
            sender_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                phase_reg    <= phase_next;
                pkt_len_reg  <= pkt_len_next;
                pos_reg      <= pos_next;
                seg_len_reg  <= seg_len_next;
                seg_cmd_reg  <= seg_cmd_next;
                data_cnt_reg <= data_cnt_next;
                sender_reg   <= sender_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

[hdl/segmented_command_deframer_core.sv]
// ----------------------------------------------------------------------------
// Segmented command deframer core: byte -> input register -> result register.
// One byte per cycle unless results stall; input register feeds one parse step.
// Asynchronous active-low reset: waits for a header first byte, max length 96.
// ----------------------------------------------------------------------------
`include "segmented_command_deframer_core_defines.svh"

module segmented_command_deframer_core
    import scdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    scdf_byte_if.sink          byte_ch,
    scdf_result_if.source      result_ch
);

    in_item_t  in_item;
    in_item_t  stage_item;
    logic      stage_valid;
    logic      advance;
    logic      res_valid;
    out_item_t res;

    assign in_item.data_byte     = byte_ch.data_byte;
    assign in_item.first_byte    = byte_ch.first_byte;
    assign in_item.datagram_size = byte_ch.datagram_size;
    assign in_item.sender_id     = byte_ch.sender_id;

    scdf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_ch.valid),
        .in_ready (byte_ch.ready),
        .in_item  (in_item),
        .advance  (advance),
        .valid    (stage_valid),
        .item     (stage_item)
    );

    scdf_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .valid       (stage_valid),
        .item        (stage_item),
        .advance     (advance),
        .res_ready   (result_ch.ready),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign result_ch.valid            = res_valid;
    assign result_ch.status           = res.status;
    assign result_ch.command          = res.command;
    assign result_ch.sender           = res.sender;
    assign result_ch.segment_data_len = res.segment_data_len;
    assign result_ch.has_data         = res.has_data;
    assign result_ch.payload_byte     = res.payload_byte;
    assign result_ch.byte_index       = res.byte_index;
    assign result_ch.segment_end      = res.segment_end;

    `SCDF_ASSERT_IMP(a_error_bare, clk, rst_n, res_valid && res.status != STATUS_OK, !res.has_data && !res.segment_end && res.command == 8'd0)
    `SCDF_ASSERT_IMP(a_index_range, clk, rst_n, res_valid && res.has_data, res.byte_index < res.segment_data_len)
    `SCDF_ASSERT_NEXT(a_stage_hold, clk, rst_n, stage_valid && !advance, stage_valid && $stable(stage_item))

endmodule
